// ----- design/cfpti_pkg.sv -----
package cfpti_pkg;

    localparam int REG_W          = 24;
    localparam int COUNT_BITS_DEF = 24;
    localparam int SCALE_W        = 2;
    localparam int COLOR_W        = 2;
    localparam int IDX_W          = 3;
    localparam int QUOT_W         = 8;
    localparam int BIT_W          = $clog2(QUOT_W);
    localparam int IN_TDATA_W     = 8;
    localparam int OUT_TDATA_W    = 40;

    localparam logic [QUOT_W-1:0] FULL_SCALE = 8'd255;

    localparam logic [COLOR_W-1:0] COLOR_RED     = 2'd0;
    localparam logic [COLOR_W-1:0] COLOR_GREEN   = 2'd1;
    localparam logic [COLOR_W-1:0] COLOR_BLUE    = 2'd2;
    localparam logic [COLOR_W-1:0] COLOR_INVALID = 2'd3;

    localparam logic [IDX_W-1:0] REG_SCALE_MODE = 3'd0;
    localparam logic [IDX_W-1:0] REG_RED_MIN    = 3'd1;
    localparam logic [IDX_W-1:0] REG_RED_MAX    = 3'd2;
    localparam logic [IDX_W-1:0] REG_GREEN_MIN  = 3'd3;
    localparam logic [IDX_W-1:0] REG_GREEN_MAX  = 3'd4;
    localparam logic [IDX_W-1:0] REG_BLUE_MIN   = 3'd5;
    localparam logic [IDX_W-1:0] REG_BLUE_MAX   = 3'd6;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_FIRST,
        PH_SECOND
    } phase_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_SCALE,
        ST_CHECK,
        ST_ITER,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [SCALE_W-1:0]    scale_mode;
        logic [2:0][REG_W-1:0] period_min;
        logic [2:0][REG_W-1:0] period_max;
    } cfg_t;

    typedef struct packed {
        logic             take;
        logic             load_plain;
        logic             prep;
        logic             scale;
        logic             check;
        logic             iter;
        logic             load_div;
        logic [BIT_W-1:0] bit_idx;
    } cmd_t;

    function automatic logic [REG_W-1:0] sel_period(input logic [2:0][REG_W-1:0] arr,
                                                    input logic [COLOR_W-1:0] color);
        logic [REG_W-1:0] val;
        case (color)
            COLOR_GREEN: val = arr[1];
            COLOR_BLUE:  val = arr[2];
            default:     val = arr[0];
        endcase
        return val;
    endfunction

endpackage

// ----- design/color_filter_period_to_intensity.sv -----
// Color light-to-frequency sensor reader with period capture and intensity mapping.
// Input stream: one transfer per sensor tick or start request. s_tuser is the request
// type (0 tick, 1 start); s_tdata carries the color choice and the sampled sensor level.
// Output stream: exactly one transfer per input transfer, carrying the scaling and filter
// pin levels, a done flag in m_tuser, and on completion the color, period and intensity.
// The configuration port writes the scale mode and the per-color min and max periods.
// A tick that does not complete a measurement gives its result in the cycle after the
// input transfer, and one item per cycle is sustained while the receiver keeps up.
// The tick that closes a measurement starts a restoring division over a shared
// subtractor, one quotient bit per cycle, so its result passes the prepare, scale, check,
// iterate and done states before it transfers, and no input is taken meanwhile.
// Reset clears the time base, the capture phase and the output valid flag, selects red
// and loads the default min and max periods. When the receiver stalls, the single output
// register holds its result and s_tready stays low until that result is taken.
module color_filter_period_to_intensity #(
    parameter int COUNT_BITS = cfpti_pkg::COUNT_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // color_choice[1:0], sensor_level[2], zero padding above
    input  logic [cfpti_pkg::IN_TDATA_W-1:0]  s_tdata,
    // req_type
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // scale_pin_a[0], scale_pin_b[1], filter_pin_a[2], filter_pin_b[3],
    // measured_color[5:4], period_ticks[29:6], intensity[37:30], zero padding above
    output logic [cfpti_pkg::OUT_TDATA_W-1:0] m_tdata,
    // measure_done
    output logic                              m_tuser,
    input  logic                              cfg_we,
    input  logic [cfpti_pkg::IDX_W-1:0]       cfg_index,
    input  logic [cfpti_pkg::REG_W-1:0]       cfg_data
);
    import cfpti_pkg::*;

    cfg_t cfg;
    cmd_t cmd;
    logic completes;

    cfpti_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    cfpti_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .completes (completes),
        .cmd       (cmd)
    );

    cfpti_dp #(
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd       (cmd),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .completes (completes),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

// ----- design/cfpti_cfg.sv -----
module cfpti_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [cfpti_pkg::IDX_W-1:0] cfg_index,
    input  logic [cfpti_pkg::REG_W-1:0] cfg_data,
    output cfpti_pkg::cfg_t             cfg
);
    import cfpti_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_SCALE_MODE: cfg_next.scale_mode    = cfg_data[SCALE_W-1:0];
                REG_RED_MIN:    cfg_next.period_min[0] = cfg_data;
                REG_RED_MAX:    cfg_next.period_max[0] = cfg_data;
                REG_GREEN_MIN:  cfg_next.period_min[1] = cfg_data;
                REG_GREEN_MAX:  cfg_next.period_max[1] = cfg_data;
                REG_BLUE_MIN:   cfg_next.period_min[2] = cfg_data;
                REG_BLUE_MAX:   cfg_next.period_max[2] = cfg_data;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.scale_mode <= '0;
            cfg_reg.period_min <= '0;
            cfg_reg.period_max <= '1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- design/cfpti_ctrl.sv -----
module cfpti_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    output logic            m_tvalid,
    input  logic            m_tready,
    input  logic            completes,
    output cfpti_pkg::cmd_t cmd
);
    import cfpti_pkg::*;

    state_t           state_reg;
    state_t           state_next;
    logic [BIT_W-1:0] bit_reg;
    logic [BIT_W-1:0] bit_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             slot_free;

    assign slot_free = !out_valid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE) && slot_free;
    assign m_tvalid  = out_valid_reg;

    always_comb
    begin
        state_next  = state_reg;
        bit_next    = bit_reg;
        cmd         = '0;
        cmd.bit_idx = bit_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid && slot_free)
                begin
                    cmd.take = 1'b1;
                    if (completes)
                    begin
                        state_next = ST_PREP;
                    end
                    else
                    begin
                        cmd.load_plain = 1'b1;
                    end
                end
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                cmd.check  = 1'b1;
                bit_next   = BIT_W'(QUOT_W - 1);
                state_next = ST_ITER;
            end
            ST_ITER:
            begin
                cmd.iter = 1'b1;
                if (bit_reg == '0)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    bit_next = bit_reg - 1'b1;
                end
            end
            ST_DONE:
            begin
                if (slot_free)
                begin
                    cmd.load_div = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.load_plain || cmd.load_div)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            bit_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bit_reg       <= bit_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- design/cfpti_dp.sv -----
module cfpti_dp #(
    parameter int COUNT_BITS = cfpti_pkg::COUNT_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  cfpti_pkg::cfg_t                   cfg,
    input  cfpti_pkg::cmd_t                   cmd,
    input  logic [cfpti_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  logic                              s_tuser,
    output logic                              completes,
    output logic [cfpti_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic                              m_tuser
);
    import cfpti_pkg::*;

    localparam int DW = ((COUNT_BITS > REG_W) ? COUNT_BITS : REG_W) + 1;
    localparam int AW = DW + QUOT_W - 1;

    logic [COUNT_BITS-1:0]  time_base_reg;
    logic [COUNT_BITS-1:0]  time_base_next;
    logic                   prev_level_reg;
    logic                   prev_level_next;
    phase_t                 phase_reg;
    phase_t                 phase_next;
    logic [COUNT_BITS-1:0]  first_edge_reg;
    logic [COUNT_BITS-1:0]  first_edge_next;
    logic [COLOR_W-1:0]     color_reg;
    logic [COLOR_W-1:0]     color_next;

    logic [COUNT_BITS-1:0]  period_reg;
    logic signed [DW-1:0]   diff_reg;
    logic signed [REG_W:0]  den_reg;
    logic [AW-1:0]          rem_reg;
    logic [REG_W-1:0]       divisor_reg;
    logic                   neg_reg;
    logic                   den_zero_reg;
    logic                   sat_reg;
    logic [QUOT_W-1:0]      quot_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;
    logic                   m_tuser_reg;

    logic                   req;
    logic [COLOR_W-1:0]     choice;
    logic                   level;
    logic                   rising;
    logic [REG_W-1:0]       lo;
    logic [REG_W-1:0]       hi;
    logic [DW-1:0]          period_ext;
    logic [DW-1:0]          diff_abs_w;
    logic [DW-2:0]          mag;
    logic [REG_W:0]         den_abs_w;
    logic [AW:0]            shifted;
    logic [AW:0]            trial;
    logic [QUOT_W-1:0]      intensity;

    function automatic logic [OUT_TDATA_W-1:0] pack_out(
        input logic [SCALE_W-1:0] mode,
        input logic [COLOR_W-1:0] pin_color,
        input logic [COLOR_W-1:0] mcolor,
        input logic [REG_W-1:0]   period,
        input logic [QUOT_W-1:0]  inten
    );
        logic [OUT_TDATA_W-1:0] word;
        word        = '0;
        word[0]     = mode[1];
        word[1]     = mode[0];
        word[2]     = (pin_color == COLOR_GREEN);
        word[3]     = (pin_color == COLOR_GREEN) || (pin_color == COLOR_BLUE);
        word[5:4]   = mcolor;
        word[29:6]  = period;
        word[37:30] = inten;
        return word;
    endfunction

    assign req       = s_tuser;
    assign choice    = s_tdata[1:0];
    assign level     = s_tdata[2];
    assign rising    = level && !prev_level_reg;
    assign completes = !req && rising && (phase_reg == PH_SECOND);

    always_comb
    begin
        time_base_next  = time_base_reg;
        prev_level_next = prev_level_reg;
        phase_next      = phase_reg;
        first_edge_next = first_edge_reg;
        color_next      = color_reg;
        if (cmd.take)
        begin
            if (req)
            begin
                if (choice != COLOR_INVALID)
                begin
                    color_next = choice;
                    phase_next = PH_FIRST;
                end
            end
            else
            begin
                if (rising && (phase_reg == PH_FIRST))
                begin
                    first_edge_next = time_base_reg;
                    phase_next      = PH_SECOND;
                end
                else if (completes)
                begin
                    phase_next = PH_IDLE;
                end
                prev_level_next = level;
                time_base_next  = time_base_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_base_reg  <= '0;
            prev_level_reg <= 1'b0;
            phase_reg      <= PH_IDLE;
            first_edge_reg <= '0;
            color_reg      <= COLOR_RED;
        end
        else
        begin
            time_base_reg  <= time_base_next;
            prev_level_reg <= prev_level_next;
            phase_reg      <= phase_next;
            first_edge_reg <= first_edge_next;
            color_reg      <= color_next;
        end
    end

    assign lo         = sel_period(cfg.period_min, color_reg);
    assign hi         = sel_period(cfg.period_max, color_reg);
    assign period_ext = DW'(period_reg);
    assign diff_abs_w = diff_reg[DW-1] ? DW'(-diff_reg) : DW'(diff_reg);
    assign mag        = diff_abs_w[DW-2:0];
    assign den_abs_w  = den_reg[REG_W] ? (REG_W+1)'(-den_reg) : (REG_W+1)'(den_reg);
    assign shifted    = (AW+1)'(divisor_reg) << cmd.bit_idx;
    assign trial      = {1'b0, rem_reg} - shifted;

    always_comb
    begin
        if (den_zero_reg || (!neg_reg && sat_reg))
        begin
            intensity = '0;
        end
        else if (neg_reg)
        begin
            intensity = FULL_SCALE;
        end
        else
        begin
            intensity = FULL_SCALE - quot_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take && completes)
        begin
            period_reg <= time_base_reg - first_edge_reg;
        end
        if (cmd.prep)
        begin
            diff_reg <= $signed(period_ext) - $signed(DW'(lo));
            den_reg  <= $signed({1'b0, hi}) - $signed({1'b0, lo});
        end
        if (cmd.scale)
        begin
            rem_reg      <= {mag, QUOT_W'(0)} - AW'(mag);
            divisor_reg  <= den_abs_w[REG_W-1:0];
            neg_reg      <= diff_reg[DW-1] ^ den_reg[REG_W];
            den_zero_reg <= (den_reg == '0);
        end
        if (cmd.check)
        begin
            sat_reg  <= (rem_reg >= AW'({divisor_reg, QUOT_W'(0)}));
            quot_reg <= '0;
        end
        if (cmd.iter && !trial[AW])
        begin
            rem_reg                <= trial[AW-1:0];
            quot_reg[cmd.bit_idx] <= 1'b1;
        end
        if (cmd.load_plain)
        begin
            m_tdata_reg <= pack_out(cfg.scale_mode, color_next, '0, '0, '0);
            m_tuser_reg <= 1'b0;
        end
        else if (cmd.load_div)
        begin
            m_tdata_reg <= pack_out(cfg.scale_mode, color_reg, color_reg,
                                    period_ext[REG_W-1:0], intensity);
            m_tuser_reg <= 1'b1;
        end
    end

    assign m_tdata = m_tdata_reg;
    assign m_tuser = m_tuser_reg;

endmodule

// ----- bench/color_capture_checker.sv -----
`timescale 1ns / 100ps

module color_capture_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [cfpti_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  logic                              s_tuser,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [cfpti_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  logic                              m_tuser,
    input  logic                              cfg_we,
    input  logic [cfpti_pkg::IDX_W-1:0]       cfg_index,
    input  logic [cfpti_pkg::REG_W-1:0]       cfg_data,
    output int                                errors,
    output int                                pending
);
    import cfpti_pkg::*;

    typedef struct packed {
        logic               scale_a;
        logic               scale_b;
        logic               filter_a;
        logic               filter_b;
        logic               done;
        logic [COLOR_W-1:0] color;
        logic [REG_W-1:0]   period;
        logic [QUOT_W-1:0]  intensity;
    } reading_t;

    logic [SCALE_W-1:0] scale_mode;
    logic [REG_W-1:0]   lo_period [3];
    logic [REG_W-1:0]   hi_period [3];

    logic [REG_W-1:0]   time_base;
    logic [REG_W-1:0]   first_edge;
    logic               prev_level;
    phase_t             phase;
    logic [COLOR_W-1:0] active_color;

    reading_t readings_due [$];

    function automatic logic [QUOT_W-1:0] period_to_intensity(input logic [REG_W-1:0] period,
                                                              input logic [COLOR_W-1:0] color);
        longint lo;
        longint hi;
        longint span;
        longint full;
        longint q;
        lo   = longint'(lo_period[color]);
        hi   = longint'(hi_period[color]);
        full = longint'(FULL_SCALE);
        span = hi - lo;
        if (span == 0)
            return '0;
        q = ((longint'(period) - lo) * -full) / span + full;
        if (q < 0)
            q = 0;
        if (q > full)
            q = full;
        return q[QUOT_W-1:0];
    endfunction

    function automatic reading_t take_sample(input logic is_start,
                                             input logic [COLOR_W-1:0] choice,
                                             input logic level);
        reading_t r;
        r = '0;
        if (is_start) begin
            if (choice != COLOR_INVALID) begin
                active_color = choice;
                phase        = PH_FIRST;
            end
        end
        else begin
            if (level && !prev_level) begin
                if (phase == PH_FIRST) begin
                    first_edge = time_base;
                    phase      = PH_SECOND;
                end
                else if (phase == PH_SECOND) begin
                    r.done      = 1'b1;
                    r.color     = active_color;
                    r.period    = time_base - first_edge;
                    r.intensity = period_to_intensity(r.period, active_color);
                    phase       = PH_IDLE;
                end
            end
            prev_level = level;
            time_base  = time_base + 1'b1;
        end
        r.scale_a  = scale_mode[1];
        r.scale_b  = scale_mode[0];
        r.filter_a = (active_color == COLOR_GREEN);
        r.filter_b = (active_color == COLOR_GREEN) || (active_color == COLOR_BLUE);
        return r;
    endfunction

    function automatic void check_field(input string name, input longint unsigned want,
                                        input longint unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            errors++;
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        reading_t want;
        if (!rst_n) begin
            scale_mode   = '0;
            for (int c = 0; c < 3; c++) begin
                lo_period[c] = '0;
                hi_period[c] = '1;
            end
            time_base    = '0;
            first_edge   = '0;
            prev_level   = 1'b0;
            phase        = PH_IDLE;
            active_color = COLOR_RED;
            readings_due.delete();
            pending      = 0;
        end
        else begin
            if (m_tvalid && m_tready) begin
                if (readings_due.size() == 0) begin
                    $error("output transfer with no input transfer outstanding");
                    errors++;
                end
                else begin
                    want = readings_due.pop_front();
                    check_field("scale_pin_a", 64'(want.scale_a), 64'(m_tdata[0]));
                    check_field("scale_pin_b", 64'(want.scale_b), 64'(m_tdata[1]));
                    check_field("filter_pin_a", 64'(want.filter_a), 64'(m_tdata[2]));
                    check_field("filter_pin_b", 64'(want.filter_b), 64'(m_tdata[3]));
                    check_field("measure_done", 64'(want.done), 64'(m_tuser));
                    check_field("measured_color", 64'(want.color), 64'(m_tdata[5:4]));
                    check_field("period_ticks", 64'(want.period), 64'(m_tdata[29:6]));
                    check_field("intensity", 64'(want.intensity), 64'(m_tdata[37:30]));
                    check_field("tdata_padding", 64'(0), 64'(m_tdata[OUT_TDATA_W-1:38]));
                end
            end
            if (s_tvalid && s_tready)
                readings_due.push_back(take_sample(s_tuser, s_tdata[1:0], s_tdata[2]));
            if (cfg_we) begin
                case (cfg_index)
                    REG_SCALE_MODE: scale_mode   = cfg_data[SCALE_W-1:0];
                    REG_RED_MIN:    lo_period[0] = cfg_data;
                    REG_RED_MAX:    hi_period[0] = cfg_data;
                    REG_GREEN_MIN:  lo_period[1] = cfg_data;
                    REG_GREEN_MAX:  hi_period[1] = cfg_data;
                    REG_BLUE_MIN:   lo_period[2] = cfg_data;
                    REG_BLUE_MAX:   hi_period[2] = cfg_data;
                    default:        ;
                endcase
            end
            pending = readings_due.size();
        end
    end

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 100ps

module tb;
    import cfpti_pkg::*;

    localparam logic             REQ_TICK     = 1'b0;
    localparam logic             REQ_START    = 1'b1;
    localparam logic [IDX_W-1:0] REG_UNUSED   = 3'd7;
    localparam logic [REG_W-1:0] PERIOD_TOP   = 24'hFFFFFF;
    localparam int               RANDOM_ITEMS = 1730;
    localparam int               NUM_PHASES   = 7;
    localparam int               DRAIN_CYCLES = 20;
    localparam int               CYCLE_LIMIT  = 200000;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                   s_tuser   = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tuser;
    logic                   cfg_we    = 1'b0;
    logic [IDX_W-1:0]       cfg_index = '0;
    logic [REG_W-1:0]       cfg_data  = '0;

    int errors;
    int pending;
    int items_sent = 0;
    int gap_pct    = 30;
    int stall_pct  = 30;
    int cycles;

    always #5 clk = ~clk;

    color_filter_period_to_intensity dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    color_capture_checker capture_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    task automatic send_item(input logic req, input logic [COLOR_W-1:0] color,
                             input logic level);
        if ($urandom_range(99) < gap_pct)
            repeat ($urandom_range(1, 5)) @(negedge clk);
        s_tvalid = 1'b1;
        s_tuser  = req;
        s_tdata  = {{(IN_TDATA_W-3){1'b0}}, level, color};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
        s_tvalid = 1'b0;
        items_sent++;
    endtask

    task automatic send_run(input logic level, input int count);
        repeat (count)
            send_item(REQ_TICK, COLOR_W'($urandom_range(0, 3)), level);
    endtask

    task automatic run_measurement(input int max_run);
        send_item(REQ_START, COLOR_W'($urandom_range(0, 2)), 1'($urandom_range(0, 1)));
        repeat ($urandom_range(2, 3)) begin
            send_run(1'b0, $urandom_range(1, max_run));
            send_run(1'b1, $urandom_range(1, max_run));
        end
    endtask

    task automatic run_broken(input int max_run);
        send_item(REQ_START, COLOR_W'($urandom_range(0, 2)), 1'($urandom_range(0, 1)));
        send_run(1'b0, $urandom_range(1, max_run));
        send_run(1'b1, $urandom_range(1, max_run));
        send_item(REQ_START, COLOR_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
        send_run(1'b0, $urandom_range(1, max_run));
        send_run(1'b1, $urandom_range(1, max_run));
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [REG_W-1:0] value);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    task automatic program_bounds(input logic [IDX_W-1:0] min_idx,
                                  input logic [IDX_W-1:0] max_idx);
        logic [REG_W-1:0] lo;
        logic [REG_W-1:0] hi;
        case ($urandom_range(0, 8))
            0: begin
                lo = '0;
                hi = PERIOD_TOP;
            end
            1: begin
                lo = PERIOD_TOP;
                hi = '0;
            end
            2: begin
                lo = ($urandom_range(0, 1) == 0) ? PERIOD_TOP
                                                 : REG_W'($urandom_range(0, 60));
                hi = lo;
            end
            3: begin
                lo = REG_W'($urandom_range(30, 60));
                hi = REG_W'($urandom_range(0, 30));
            end
            4: begin
                lo = REG_W'($urandom);
                hi = REG_W'($urandom);
            end
            default: begin
                lo = REG_W'($urandom_range(0, 20));
                hi = lo + REG_W'($urandom_range(1, 60));
            end
        endcase
        write_reg(min_idx, lo);
        write_reg(max_idx, hi);
    endtask

    task automatic settle();
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    initial begin
        forever begin
            @(negedge clk);
            if ($urandom_range(99) < stall_pct) begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 5)) @(negedge clk);
            end
            m_tready = 1'b1;
        end
    end

    initial begin
        for (cycles = 0; cycles < CYCLE_LIMIT; cycles++)
            @(posedge clk);
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        int               ph;
        int               base;
        int               max_run;
        logic [REG_W-1:0] word;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset bounds: a rising edge while idle, an ignored start, restarts of the arm,
        // and a rising level that holds high without forming an edge.
        send_item(REQ_TICK, COLOR_RED, 1'b1);
        send_item(REQ_TICK, COLOR_INVALID, 1'b0);
        send_item(REQ_START, COLOR_INVALID, 1'b1);
        send_item(REQ_START, COLOR_GREEN, 1'b0);
        send_item(REQ_START, COLOR_BLUE, 1'b1);
        send_item(REQ_START, COLOR_RED, 1'b0);
        send_item(REQ_TICK, COLOR_GREEN, 1'b1);
        send_item(REQ_TICK, COLOR_BLUE, 1'b0);
        send_item(REQ_TICK, COLOR_RED, 1'b1);
        send_item(REQ_START, COLOR_GREEN, 1'b1);
        send_item(REQ_TICK, COLOR_RED, 1'b0);
        send_item(REQ_TICK, COLOR_RED, 1'b1);
        send_item(REQ_TICK, COLOR_RED, 1'b1);
        send_item(REQ_START, COLOR_BLUE, 1'b0);
        send_item(REQ_TICK, COLOR_RED, 1'b0);
        send_item(REQ_TICK, COLOR_RED, 1'b1);
        send_item(REQ_TICK, COLOR_RED, 1'b0);
        send_item(REQ_TICK, COLOR_RED, 1'b1);
        settle();

        // Inverted green bounds with a period below both, equal blue bounds,
        // and a scale mode written with upper bits set.
        write_reg(REG_SCALE_MODE, 24'hABCDE7);
        write_reg(REG_RED_MIN, 24'd4);
        write_reg(REG_RED_MAX, 24'd40);
        write_reg(REG_GREEN_MIN, 24'd40);
        write_reg(REG_GREEN_MAX, 24'd4);
        write_reg(REG_BLUE_MIN, 24'd10);
        write_reg(REG_BLUE_MAX, 24'd10);
        write_reg(REG_UNUSED, PERIOD_TOP);
        send_item(REQ_START, COLOR_GREEN, 1'b0);
        send_item(REQ_TICK, COLOR_RED, 1'b0);
        send_item(REQ_TICK, COLOR_RED, 1'b1);
        send_item(REQ_TICK, COLOR_RED, 1'b0);
        send_item(REQ_TICK, COLOR_RED, 1'b0);
        send_item(REQ_TICK, COLOR_RED, 1'b1);

        base = items_sent;
        for (ph = 0; ph < NUM_PHASES; ph++) begin
            settle();
            word = REG_W'($urandom);
            word[SCALE_W-1:0] = ph[SCALE_W-1:0];
            write_reg(REG_SCALE_MODE, word);
            program_bounds(REG_RED_MIN, REG_RED_MAX);
            program_bounds(REG_GREEN_MIN, REG_GREEN_MAX);
            program_bounds(REG_BLUE_MIN, REG_BLUE_MAX);
            write_reg(REG_UNUSED, REG_W'($urandom));

            if (ph == NUM_PHASES - 1) begin
                gap_pct   = 0;
                stall_pct = 0;
            end
            else begin
                gap_pct   = 20 * $urandom_range(0, 2);
                stall_pct = 20 * $urandom_range(0, 2);
            end
            case ($urandom_range(0, 2))
                0:       max_run = 2;
                1:       max_run = 6;
                default: max_run = 20;
            endcase

            while (items_sent < base + (ph + 1) * RANDOM_ITEMS / NUM_PHASES) begin
                case ($urandom_range(0, 9))
                    8:       run_broken(max_run);
                    9:       repeat ($urandom_range(1, 8))
                                 send_item(1'($urandom_range(0, 1)),
                                           COLOR_W'($urandom_range(0, 3)),
                                           1'($urandom_range(0, 1)));
                    default: run_measurement(max_run);
                endcase
            end
        end

        settle();
        if (errors == 0 && pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
